// File: rtl/qualified_field_splitter_assert.svh
// Assertion macros shared by the splitter RTL.
// Depends on nothing; included at the end of the modules that check themselves.
`ifndef QUALIFIED_FIELD_SPLITTER_ASSERT_SVH
`define QUALIFIED_FIELD_SPLITTER_ASSERT_SVH

// Property must hold on every clock edge outside reset.
`define QFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define QFS_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// File: rtl/qfs_pkg.sv
// Shared types for the qualified field splitter: result kinds and queue entry.
// No dependencies.
`default_nettype none

package qfs_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_PART = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } qfs_kind_e;

  // Up to two results per input beat; the second is always DONE or ERR after a PART.
  typedef struct packed {
    logic      first_v;
    qfs_kind_e first_k;
    logic      second_v;
    qfs_kind_e second_k;
  } qfs_op_t;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUALIFIER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_EMPTY = 2'd2;

endpackage

`default_nettype wire

// File: rtl/qfs_front.sv
// Front end: config registers, parse state and per-beat classification.
// Depends on qfs_pkg.
`default_nettype none

module qfs_front import qfs_pkg::*; #(
  parameter int unsigned CHAR_WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CHAR_WIDTH-1:0] cfg_data_i,
  input  wire logic                  accept_i,
  input  wire logic [CHAR_WIDTH-1:0] code_unit_i,
  input  wire logic                  end_of_text_i,
  output qfs_op_t                    op_o,
  output logic      [CHAR_WIDTH-1:0] char_o
);

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_PLAIN  = 3'd1;
  localparam logic [2:0] PH_QUOTED = 3'd2;
  localparam logic [2:0] PH_CLOSED = 3'd3;
  localparam logic [2:0] PH_FAILED = 3'd4;

  logic [CHAR_WIDTH-1:0] sep_q, qual_q;
  logic                  keep_q;
  logic [2:0]            phase_q, phase_d;
  logic                  has_q, has_d;

  logic is_q, is_sep, close_ok;
  logic want_part, want_char, want_done, want_err;

  assign is_q     = (qual_q != '0) && (code_unit_i == qual_q);
  assign is_sep   = (code_unit_i == sep_q);
  assign close_ok = has_q | keep_q;

  always_comb begin
    want_part = 1'b0;
    want_char = 1'b0;
    want_done = 1'b0;
    want_err  = 1'b0;
    phase_d   = phase_q;
    has_d     = has_q;
    if (end_of_text_i) begin
      unique case (phase_q)
        PH_START, PH_PLAIN, PH_CLOSED: begin
          want_part = close_ok;
          want_done = 1'b1;
        end
        PH_QUOTED: want_err = 1'b1;
        default: ;
      endcase
      phase_d = PH_START;
      has_d   = 1'b0;
    end else begin
      unique case (phase_q)
        PH_START: begin
          priority if (is_q) begin
            phase_d = PH_QUOTED;
            has_d   = 1'b0;
          end else if (is_sep) begin
            want_part = close_ok;
            has_d     = 1'b0;
          end else begin
            want_char = 1'b1;
            has_d     = 1'b1;
            phase_d   = PH_PLAIN;
          end
        end
        PH_PLAIN: begin
          if (is_sep) begin
            want_part = close_ok;
            has_d     = 1'b0;
            phase_d   = PH_START;
          end else begin
            want_char = 1'b1;
            has_d     = 1'b1;
          end
        end
        PH_QUOTED: begin
          if (is_q) begin
            phase_d = PH_CLOSED;
          end else begin
            want_char = 1'b1;
            has_d     = 1'b1;
          end
        end
        PH_CLOSED: begin
          want_part = close_ok;
          has_d     = 1'b0;
          if (is_sep) begin
            phase_d = PH_START;
          end else begin
            want_err = 1'b1;
            phase_d  = PH_FAILED;
          end
        end
        default: ;
      endcase
    end
  end

  // Pack: PART always leads; CHAR stands alone; DONE/ERR trail a PART if any.
  always_comb begin
    op_o.first_v  = want_part | want_char | want_done | want_err;
    op_o.first_k  = want_part ? KIND_PART :
                    want_char ? KIND_CHAR :
                    want_done ? KIND_DONE : KIND_ERR;
    op_o.second_v = want_part & (want_done | want_err);
    op_o.second_k = want_done ? KIND_DONE : KIND_ERR;
    char_o        = want_char ? code_unit_i : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= CHAR_WIDTH'(44);
      qual_q  <= CHAR_WIDTH'(34);
      keep_q  <= 1'b1;
      phase_q <= PH_START;
      has_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SEPARATOR:  sep_q  <= cfg_data_i;
          CFG_QUALIFIER:  qual_q <= cfg_data_i;
          CFG_KEEP_EMPTY: keep_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept_i) begin
        phase_q <= phase_d;
        has_q   <= has_d;
      end
    end
  end

`include "qualified_field_splitter_assert.svh"

  `QFS_ASSERT(a_eot_restarts, clk_i, rst_ni, accept_i && end_of_text_i |=> phase_q == PH_START, "end of text did not return to start")
  `QFS_ASSERT(a_second_after_part, clk_i, rst_ni, op_o.second_v |-> op_o.first_k == KIND_PART, "second result without leading part")

endmodule

`default_nettype wire

// File: rtl/qfs_fifo.sv
// Small queue between the classifier and the result stage.
// No package dependency.
`default_nettype none

module qfs_fifo #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] din_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [WIDTH-1:0] dout_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

`include "qualified_field_splitter_assert.svh"

  `QFS_NEVER(a_fifo_overfill, clk_i, rst_ni, count_q > CNT_W'(DEPTH), "queue count above depth")

endmodule

`default_nettype wire

// File: rtl/qfs_emit.sv
// Result stage: output register that steps through one or two results per entry.
// Depends on qfs_pkg.
`default_nettype none

module qfs_emit import qfs_pkg::*; #(
  parameter int unsigned CHAR_WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  head_valid_i,
  input  wire qfs_op_t               head_op_i,
  input  wire logic [CHAR_WIDTH-1:0] head_char_i,
  output logic                       head_pop_o,
  input  wire logic                  pop_i,
  output logic                       empty_o,
  output logic      [1:0]            kind_o,
  output logic      [CHAR_WIDTH-1:0] part_char_o
);

  logic                  out_v_q;
  logic                  out_sel_q;
  qfs_op_t               out_op_q;
  logic [CHAR_WIDTH-1:0] out_char_q;
  logic                  last, take, load;

  assign last       = out_sel_q | ~out_op_q.second_v;
  assign take       = pop_i & out_v_q;
  assign load       = (~out_v_q | (take & last)) & head_valid_i;
  assign head_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      out_sel_q <= 1'b0;
      out_op_q  <= '0;
    end else begin
      if (load) begin
        out_v_q   <= 1'b1;
        out_sel_q <= 1'b0;
        out_op_q  <= head_op_i;
      end else if (take && !last) begin
        out_sel_q <= 1'b1;
      end else if (take) begin
        out_v_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= head_char_i;
    end
  end

  assign empty_o     = ~out_v_q;
  assign kind_o      = out_sel_q ? out_op_q.second_k : out_op_q.first_k;
  assign part_char_o = out_sel_q ? '0 : out_char_q;

`include "qualified_field_splitter_assert.svh"

  `QFS_NEVER(a_sel_needs_second, clk_i, rst_ni, out_v_q && out_sel_q && !out_op_q.second_v, "second slot shown without second result")
  `QFS_ASSERT(a_second_follows, clk_i, rst_ni, take && !last |=> out_v_q && out_sel_q, "second result of a beat lost")

endmodule

`default_nettype wire

// File: rtl/qualified_field_splitter.sv
// Path: an accepted beat's results are written into the queue, then loaded into the output
//   register once it is free; the output register drives the ports.
// Throughput: one input beat per cycle while the queue has room; one result per cycle
//   out while pop is high, so a two-result beat holds the output register for two pops.
// Reset (rst_ni low, async): queue and output emptied, parser at start of a part,
//   separator ',', qualifier '"', empty parts kept.
`default_nettype none

module qualified_field_splitter import qfs_pkg::*; #(
  parameter int unsigned CHAR_WIDTH = 16,
  parameter int unsigned QDEPTH     = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes, only while idle
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CHAR_WIDTH-1:0] cfg_data_i,
  // input beats
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [CHAR_WIDTH-1:0] code_unit_i,
  input  wire logic                  end_of_text_i,
  // result beats
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [1:0]            kind_o,
  output logic      [CHAR_WIDTH-1:0] part_char_o
);

  localparam int unsigned OP_W    = $bits(qfs_op_t);
  localparam int unsigned ENTRY_W = OP_W + CHAR_WIDTH;

  logic                  accept;
  qfs_op_t               front_op;
  logic [CHAR_WIDTH-1:0] front_char;
  logic                  q_full, q_empty, q_pop;
  logic [ENTRY_W-1:0]    q_dout;
  qfs_op_t               head_op;
  logic [CHAR_WIDTH-1:0] head_char;

  // A beat is taken whenever the queue has room; parser state moves on the same edge.
  assign full   = q_full;
  assign accept = push & ~q_full;

  qfs_front #(
    .CHAR_WIDTH (CHAR_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .code_unit_i   (code_unit_i),
    .end_of_text_i (end_of_text_i),
    .op_o          (front_op),
    .char_o        (front_char)
  );

  // Only beats that produce at least one result occupy a queue slot.
  qfs_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept & front_op.first_v),
    .din_i   ({front_op, front_char}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .dout_o  (q_dout)
  );

  assign head_op   = qfs_op_t'(q_dout[ENTRY_W-1:CHAR_WIDTH]);
  assign head_char = q_dout[CHAR_WIDTH-1:0];

  // Output register; steps through the second result of an entry before refilling.
  qfs_emit #(
    .CHAR_WIDTH (CHAR_WIDTH)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (~q_empty),
    .head_op_i    (head_op),
    .head_char_i  (head_char),
    .head_pop_o   (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .kind_o       (kind_o),
    .part_char_o  (part_char_o)
  );

endmodule

`default_nettype wire
